FILE: src/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types and constants for the traffic light sequencer: payload
// structs, configuration register map and reset values, phase and lamp codes.
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int PHASE_W   = 3;
  localparam int LIGHT_W   = 2;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_GREEN_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_GREEN_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUX_GREEN_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AUX_GREEN_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_TICKS    = 3'd5;

  localparam logic [CFG_W-1:0] RST_MAIN_GREEN_MIN = 10'd100;
  localparam logic [CFG_W-1:0] RST_MAIN_GREEN_MAX = 10'd600;
  localparam logic [CFG_W-1:0] RST_AUX_GREEN_MIN  = 10'd100;
  localparam logic [CFG_W-1:0] RST_AUX_GREEN_MAX  = 10'd300;
  localparam logic [CFG_W-1:0] RST_YELLOW_TICKS   = 10'd60;
  localparam logic [CFG_W-1:0] RST_CLEAR_TICKS    = 10'd20;

  // lamp codes
  localparam logic [LIGHT_W-1:0] LIGHT_RED    = 2'd0;
  localparam logic [LIGHT_W-1:0] LIGHT_YELLOW = 2'd1;
  localparam logic [LIGHT_W-1:0] LIGHT_GREEN  = 2'd2;

  // phase numbers as reported
  localparam logic [PHASE_W-1:0] PNUM_AUX_YELLOW  = 3'd0;
  localparam logic [PHASE_W-1:0] PNUM_CLEAR_A     = 3'd1;
  localparam logic [PHASE_W-1:0] PNUM_MAIN_GREEN  = 3'd2;
  localparam logic [PHASE_W-1:0] PNUM_MAIN_YELLOW = 3'd3;
  localparam logic [PHASE_W-1:0] PNUM_CLEAR_B     = 3'd4;
  localparam logic [PHASE_W-1:0] PNUM_AUX_GREEN   = 3'd5;

  typedef enum logic [5:0] {
    PH_AUX_YELLOW  = 6'b000001,
    PH_CLEAR_A     = 6'b000010,
    PH_MAIN_GREEN  = 6'b000100,
    PH_MAIN_YELLOW = 6'b001000,
    PH_CLEAR_B     = 6'b010000,
    PH_AUX_GREEN   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic main_ped_button;
    logic aux_ped_button;
    logic car_sensor_a;
    logic car_sensor_b;
  } tls_in_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LIGHT_W-1:0] main_light;
    logic [LIGHT_W-1:0] aux_light;
    logic               infraction;
  } tls_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] main_green_min;
    logic [CFG_W-1:0] main_green_max;
    logic [CFG_W-1:0] aux_green_min;
    logic [CFG_W-1:0] aux_green_max;
    logic [CFG_W-1:0] yellow_ticks;
    logic [CFG_W-1:0] clear_ticks;
  } tls_cfg_t;

  function automatic tls_out_t make_result(phase_t ph, logic infr);
    tls_out_t r;
    r.main_light = LIGHT_RED;
    r.aux_light  = LIGHT_RED;
    r.infraction = infr;
    case (ph)
      PH_AUX_YELLOW: begin
        r.phase     = PNUM_AUX_YELLOW;
        r.aux_light = LIGHT_YELLOW;
      end
      PH_MAIN_GREEN: begin
        r.phase      = PNUM_MAIN_GREEN;
        r.main_light = LIGHT_GREEN;
      end
      PH_MAIN_YELLOW: begin
        r.phase      = PNUM_MAIN_YELLOW;
        r.main_light = LIGHT_YELLOW;
      end
      PH_CLEAR_B: begin
        r.phase = PNUM_CLEAR_B;
      end
      PH_AUX_GREEN: begin
        r.phase     = PNUM_AUX_GREEN;
        r.aux_light = LIGHT_GREEN;
      end
      default: begin
        r.phase = PNUM_CLEAR_A;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: src/traffic_light_sequencer_unit.sv
// ----------------------------------------------------------------------------
// traffic_light_sequencer_unit
// An accepted tick is loaded into the input register, then into the result
// register when that is free or being drained. Throughput: one tick per
// cycle while the result side does not stall; the phase update between the
// two registers is combinational. Reset: phase 1 (all red), timer and latches
// cleared, timing registers at their defaults, no word in flight.
// ----------------------------------------------------------------------------
module traffic_light_sequencer_unit #(
  parameter int TIMER_BITS = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tls_pkg::tls_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tls_pkg::tls_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tls_pkg::CFG_W-1:0]     cfg_data
);
  import tls_pkg::*;

  tls_cfg_t regs;
  tls_in_t  item;
  logic     item_valid;
  logic     step;
  tls_out_t result;

  // input stage moves on when the result register is free or being drained
  assign step     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step;

  tls_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  tls_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .regs   (regs),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid <= 1'b1;
      end else if (step) begin
        item_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (step) begin
      out_data <= result;
    end
  end

endmodule

FILE: src/tls_cfg.sv
// ----------------------------------------------------------------------------
// tls_cfg
// Timing register file: six 10-bit tick counts written through the
// configuration channel, out-of-range indexes dropped.
// ----------------------------------------------------------------------------
module tls_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tls_pkg::CFG_W-1:0]     cfg_data,
  output tls_pkg::tls_cfg_t             regs
);
  import tls_pkg::*;

  tls_cfg_t regs_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg_valid) begin
      case (cfg_index)
        REG_MAIN_GREEN_MIN: regs_next.main_green_min = cfg_data;
        REG_MAIN_GREEN_MAX: regs_next.main_green_max = cfg_data;
        REG_AUX_GREEN_MIN:  regs_next.aux_green_min  = cfg_data;
        REG_AUX_GREEN_MAX:  regs_next.aux_green_max  = cfg_data;
        REG_YELLOW_TICKS:   regs_next.yellow_ticks   = cfg_data;
        REG_CLEAR_TICKS:    regs_next.clear_ticks    = cfg_data;
        default:            regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.main_green_min <= RST_MAIN_GREEN_MIN;
      regs.main_green_max <= RST_MAIN_GREEN_MAX;
      regs.aux_green_min  <= RST_AUX_GREEN_MIN;
      regs.aux_green_max  <= RST_AUX_GREEN_MAX;
      regs.yellow_ticks   <= RST_YELLOW_TICKS;
      regs.clear_ticks    <= RST_CLEAR_TICKS;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

FILE: src/tls_core.sv
// ----------------------------------------------------------------------------
// tls_core
// Phase state machine: sensor latches, saturating phase timer and the
// stay/leave decision, evaluated once per tick.
// ----------------------------------------------------------------------------
module tls_core #(
  parameter int TIMER_BITS = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  tls_pkg::tls_in_t   item,
  input  tls_pkg::tls_cfg_t  regs,
  output tls_pkg::tls_out_t  result
);
  import tls_pkg::*;

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  phase_t                phase;
  phase_t                phase_next;
  logic [TIMER_BITS-1:0] timer;
  logic [TIMER_BITS-1:0] timer_next;
  logic                  ped_latch;
  logic                  ped_latch_next;
  logic                  car_latch;
  logic                  car_latch_next;

  logic                  car;
  logic                  infr;
  logic                  ped_upd;
  logic                  car_upd;
  logic [TIMER_BITS-1:0] timer_inc;
  logic [CMP_W-1:0]      t_ext;
  logic [CMP_W-1:0]      lo;
  logic [CMP_W-1:0]      hi;
  logic                  hold_ok;
  logic                  stay;
  phase_t                phase_adv;

  assign car       = item.car_sensor_a | item.car_sensor_b;
  assign timer_inc = (timer == {TIMER_BITS{1'b1}}) ? timer : timer + 1'b1;
  assign t_ext     = CMP_W'(timer_inc);

  always_comb begin
    ped_upd = ped_latch;
    car_upd = car_latch;
    infr    = 1'b0;
    case (phase)
      PH_AUX_YELLOW: begin
        ped_upd = ped_latch;
      end
      PH_AUX_GREEN: begin
        if (!ped_latch) ped_upd = item.main_ped_button;
      end
      default: begin
        // aux road check, also for unused codes
        if (!ped_latch) ped_upd = item.aux_ped_button;
        if (!car_latch) begin
          car_upd = car;
        end else if (!car) begin
          infr    = 1'b1;
          car_upd = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    lo        = CMP_W'(regs.clear_ticks);
    hi        = CMP_W'(regs.clear_ticks);
    hold_ok   = !ped_upd && !car_upd;
    phase_adv = PH_MAIN_GREEN;
    case (phase)
      PH_AUX_YELLOW: begin
        lo        = CMP_W'(regs.yellow_ticks);
        hold_ok   = 1'b0;
        phase_adv = PH_CLEAR_A;
      end
      PH_MAIN_GREEN: begin
        lo        = CMP_W'(regs.main_green_min);
        hi        = CMP_W'(regs.main_green_max);
        phase_adv = PH_MAIN_YELLOW;
      end
      PH_MAIN_YELLOW: begin
        lo        = CMP_W'(regs.yellow_ticks);
        hi        = CMP_W'(regs.yellow_ticks);
        phase_adv = PH_CLEAR_B;
      end
      PH_CLEAR_B: begin
        phase_adv = PH_AUX_GREEN;
      end
      PH_AUX_GREEN: begin
        lo        = CMP_W'(regs.aux_green_min);
        hi        = CMP_W'(regs.aux_green_max);
        hold_ok   = !ped_upd;
        phase_adv = PH_AUX_YELLOW;
      end
      default: begin
        phase_adv = PH_MAIN_GREEN;
      end
    endcase
    stay = (t_ext < lo) || (hold_ok && (t_ext <= hi));
  end

  always_comb begin
    if (stay) begin
      phase_next     = phase;
      timer_next     = timer_inc;
      ped_latch_next = ped_upd;
      car_latch_next = car_upd;
    end else begin
      phase_next     = phase_adv;
      timer_next     = '0;
      ped_latch_next = 1'b0;
      car_latch_next = 1'b0;
    end
  end

  assign result = make_result(phase_next, infr);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CLEAR_A;
      timer     <= '0;
      ped_latch <= 1'b0;
      car_latch <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      timer     <= timer_next;
      ped_latch <= ped_latch_next;
      car_latch <= car_latch_next;
    end
  end

endmodule

FILE: sim/tls_light_checker.sv
// ----------------------------------------------------------------------------
// tls_light_checker
// Watches the input, result and register-write channels of the traffic light
// sequencer, runs its own copy of the phase sequencing on every accepted
// tick and compares each result word field by field with the oldest
// prediction still pending.
// ----------------------------------------------------------------------------
module tls_light_checker #(
  parameter int TIMER_BITS = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  tls_pkg::tls_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  tls_pkg::tls_out_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tls_pkg::CFG_W-1:0]     cfg_data,
  output int                            outstanding,
  output int                            errors
);

  timeunit 1ns;
  timeprecision 1ps;

  import tls_pkg::*;

  tls_cfg_t              timing;
  logic [PHASE_W-1:0]    cur_phase;
  logic [TIMER_BITS-1:0] tick_count;
  logic                  ped_req;
  logic                  car_req;
  tls_out_t              lamp_words_due[$];

  task automatic report(input string what);
    errors++;
    if (errors <= 40) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  task automatic load_timing(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_MAIN_GREEN_MIN: timing.main_green_min = val;
      REG_MAIN_GREEN_MAX: timing.main_green_max = val;
      REG_AUX_GREEN_MIN:  timing.aux_green_min  = val;
      REG_AUX_GREEN_MAX:  timing.aux_green_max  = val;
      REG_YELLOW_TICKS:   timing.yellow_ticks   = val;
      REG_CLEAR_TICKS:    timing.clear_ticks    = val;
      default: ;
    endcase
  endtask

  // one tick: sample sensors, advance timer, decide whether to move on
  function automatic tls_out_t step_lights(input tls_in_t w);
    logic               car;
    logic               infr;
    logic               hold;
    logic [CFG_W-1:0]   lo;
    logic [CFG_W-1:0]   hi;
    logic [PHASE_W-1:0] ph;
    tls_out_t           r;
    ph   = (cur_phase > PNUM_AUX_GREEN) ? PNUM_CLEAR_A : cur_phase;
    car  = w.car_sensor_a | w.car_sensor_b;
    infr = 1'b0;
    if (ph >= PNUM_CLEAR_A && ph <= PNUM_CLEAR_B) begin
      if (!ped_req) ped_req = w.aux_ped_button;
      if (!car_req) begin
        car_req = car;
      end else if (!car) begin
        // latched car gone while aux still red
        infr    = 1'b1;
        car_req = 1'b0;
      end
    end else if (ph == PNUM_AUX_GREEN) begin
      if (!ped_req) ped_req = w.main_ped_button;
    end
    if (tick_count != '1) tick_count++;
    case (ph)
      PNUM_AUX_YELLOW: begin
        hold = tick_count < timing.yellow_ticks;
      end
      PNUM_AUX_GREEN: begin
        hold = tick_count < timing.aux_green_min ||
               (!ped_req && tick_count <= timing.aux_green_max);
      end
      default: begin
        if (ph == PNUM_MAIN_GREEN) begin
          lo = timing.main_green_min;
          hi = timing.main_green_max;
        end else if (ph == PNUM_MAIN_YELLOW) begin
          lo = timing.yellow_ticks;
          hi = timing.yellow_ticks;
        end else begin
          lo = timing.clear_ticks;
          hi = timing.clear_ticks;
        end
        hold = tick_count < lo || (!ped_req && !car_req && tick_count <= hi);
      end
    endcase
    if (!hold) begin
      ph         = (ph == PNUM_AUX_GREEN) ? PNUM_AUX_YELLOW : ph + 1'b1;
      tick_count = '0;
      ped_req    = 1'b0;
      car_req    = 1'b0;
    end
    cur_phase    = ph;
    r.phase      = ph;
    r.main_light = LIGHT_RED;
    r.aux_light  = LIGHT_RED;
    r.infraction = infr;
    case (ph)
      PNUM_AUX_YELLOW:  r.aux_light  = LIGHT_YELLOW;
      PNUM_MAIN_GREEN:  r.main_light = LIGHT_GREEN;
      PNUM_MAIN_YELLOW: r.main_light = LIGHT_YELLOW;
      PNUM_AUX_GREEN:   r.aux_light  = LIGHT_GREEN;
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    tls_out_t want;
    if (rst) begin
      timing.main_green_min = RST_MAIN_GREEN_MIN;
      timing.main_green_max = RST_MAIN_GREEN_MAX;
      timing.aux_green_min  = RST_AUX_GREEN_MIN;
      timing.aux_green_max  = RST_AUX_GREEN_MAX;
      timing.yellow_ticks   = RST_YELLOW_TICKS;
      timing.clear_ticks    = RST_CLEAR_TICKS;
      cur_phase  = PNUM_CLEAR_A;
      tick_count = '0;
      ped_req    = 1'b0;
      car_req    = 1'b0;
      errors     = 0;
      lamp_words_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) load_timing(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        if (lamp_words_due.size() == 0) begin
          report($sformatf("result word %p with nothing pending", out_data));
        end else begin
          want = lamp_words_due.pop_front();
          if (out_data.phase !== want.phase)
            report($sformatf("phase %0d, want %0d", out_data.phase, want.phase));
          if (out_data.main_light !== want.main_light)
            report($sformatf("main_light %0d, want %0d", out_data.main_light, want.main_light));
          if (out_data.aux_light !== want.aux_light)
            report($sformatf("aux_light %0d, want %0d", out_data.aux_light, want.aux_light));
          if (out_data.infraction !== want.infraction)
            report($sformatf("infraction %0b, want %0b", out_data.infraction, want.infraction));
        end
      end
      if (in_valid && in_ready) lamp_words_due.push_back(step_lights(in_data));
    end
    outstanding = lamp_words_due.size();
  end

endmodule

FILE: sim/tb_traffic_light_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_traffic_light_sequencer_unit
// Drives sensor ticks and timing register writes into the sequencer with
// random gaps and back-pressure, and gives the verdict from the checker's
// mismatch count.
// ----------------------------------------------------------------------------
module tb_traffic_light_sequencer_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import tls_pkg::*;

  localparam int TIMER_BITS = 11;
  localparam int CYCLE_LIMIT = 200000;

  // indexes past the register map, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  tls_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  tls_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int   outstanding;
  int   errors;
  int   words_sent;
  int   cycles;
  logic calm;
  logic car_here;

  always #5ns clk = ~clk;

  traffic_light_sequencer_unit #(
    .TIMER_BITS(TIMER_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  tls_light_checker #(
    .TIMER_BITS(TIMER_BITS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .outstanding(outstanding),
    .errors     (errors)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off so the block backs up
  initial begin
    int   stall_left;
    logic stalled_once;
    out_ready    = 1'b0;
    stall_left   = 0;
    stalled_once = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!stalled_once && words_sent >= 300) begin
        stalled_once = 1'b1;
        stall_left   = 120;
        out_ready    <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 18);
      end
    end
  end

  task automatic send_word(input tls_in_t w);
    if (!calm) begin
      while ($urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait for every predicted word, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] mg_min, input logic [CFG_W-1:0] mg_max,
                            input logic [CFG_W-1:0] ag_min, input logic [CFG_W-1:0] ag_max,
                            input logic [CFG_W-1:0] yel, input logic [CFG_W-1:0] clr);
    drain();
    write_reg(REG_MAIN_GREEN_MIN, mg_min);
    write_reg(REG_MAIN_GREEN_MAX, mg_max);
    write_reg(REG_AUX_GREEN_MIN, ag_min);
    write_reg(REG_AUX_GREEN_MAX, ag_max);
    write_reg(REG_YELLOW_TICKS, yel);
    write_reg(REG_CLEAR_TICKS, clr);
    write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // cars arrive and leave in runs so latches fill and cars can leave on red
  task automatic random_ticks(input int n, input int btn_pct);
    tls_in_t w;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) car_here = ~car_here;
      if ($urandom_range(9) == 0) begin
        w = tls_in_t'($urandom);
      end else begin
        w.main_ped_button = $urandom_range(99) < btn_pct;
        w.aux_ped_button  = $urandom_range(99) < btn_pct;
        if (car_here) begin
          case ($urandom_range(2))
            0:       {w.car_sensor_a, w.car_sensor_b} = 2'b10;
            1:       {w.car_sensor_a, w.car_sensor_b} = 2'b01;
            default: {w.car_sensor_a, w.car_sensor_b} = 2'b11;
          endcase
        end else begin
          {w.car_sensor_a, w.car_sensor_b} = 2'b00;
        end
      end
      send_word(w);
    end
  endtask

  initial begin
    tls_in_t w;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    car_here   = 1'b0;
    words_sent = 0;
    cycles     = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // timing as after reset
    random_ticks(200, 15);

    // directed: every sensor combination, then a car that arrives and leaves
    set_timing(2, 2, 2, 2, 2, 2);
    for (int i = 0; i < 16; i++) send_word(tls_in_t'(i));
    w = '0;
    w.car_sensor_a = 1'b1;
    send_word(w);
    w = '0;
    w.car_sensor_b = 1'b1;
    send_word(w);
    send_word('0);
    w.car_sensor_a = 1'b1;
    w.car_sensor_b = 1'b1;
    send_word(w);
    send_word('0);
    w = '0;
    w.main_ped_button = 1'b1;
    send_word(w);

    set_timing(1, 1, 1, 1, 1, 1);
    random_ticks(100, 20);
    set_timing(0, 0, 0, 0, 0, 0);
    random_ticks(80, 20);
    set_timing(1023, 1023, 1023, 1023, 1023, 1023);
    random_ticks(60, 20);
    set_timing(5, 1023, 5, 1023, 1, 1);
    random_ticks(100, 3);
    // minimum above maximum
    set_timing(20, 3, 15, 2, 3, 2);
    random_ticks(100, 10);

    for (int r = 0; r < 6; r++) begin
      set_timing(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)),
                 CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)),
                 CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)));
      calm = (r == 2);
      random_ticks(100, $urandom_range(2, 30));
      calm = 1'b0;
    end

    drain();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/tls_pkg.sv
src/tls_cfg.sv
src/tls_core.sv
src/traffic_light_sequencer_unit.sv
sim/tls_light_checker.sv
sim/tb_traffic_light_sequencer_unit.sv
